[rtl/swept_box_collision_time_unit_assert.svh]
// assertion macros shared by the swept box collision time unit
`ifndef SWEPT_BOX_COLLISION_TIME_UNIT_ASSERT_SVH
`define SWEPT_BOX_COLLISION_TIME_UNIT_ASSERT_SVH

// condition must never be seen at a clock edge outside reset
`define SBCT_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sbct check failed");

// antecedent in a cycle implies consequent in the same cycle
`define SBCT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbct check failed");

`endif

[rtl/sbct_pkg.sv]
// shared constants and beat types of the swept box collision time unit
`default_nettype none
package sbct_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int TIME_BITS  = 16;
   localparam int MOVE_BITS  = 24;

   localparam int DIST_BITS  = COORD_BITS + 1;
   localparam int WU_BITS    = MOVE_BITS - FRAC_BITS;
   localparam int SW_BITS    = ((COORD_BITS > WU_BITS) ? COORD_BITS : WU_BITS) + 1;
   localparam int QUO_BITS   = COORD_BITS + FRAC_BITS + TIME_BITS;
   localparam int RADIX_BITS = 2;
   localparam int DIV_STAGES = (QUO_BITS + RADIX_BITS - 1) / RADIX_BITS;
   localparam int NUM_BITS   = DIV_STAGES * RADIX_BITS;
   localparam int TQ_BITS    = NUM_BITS + 3;

   localparam int MID_DEPTH   = 4;
   localparam int MID_AW      = $clog2(MID_DEPTH);
   localparam int OUT_DEPTH   = 32;
   localparam int OUT_AW      = $clog2(OUT_DEPTH);
   localparam int CREDIT_BITS = $clog2(OUT_DEPTH + 1);

   localparam int LANES   = 4;
   localparam int LANE_XE = 0;
   localparam int LANE_XX = 1;
   localparam int LANE_YE = 2;
   localparam int LANE_YX = 3;

   localparam logic [1:0] SIDE_RIGHT  = 2'd0;
   localparam logic [1:0] SIDE_LEFT   = 2'd1;
   localparam logic [1:0] SIDE_BOTTOM = 2'd2;
   localparam logic [1:0] SIDE_TOP    = 2'd3;

   localparam logic signed [TQ_BITS-1:0] T_ONE = TQ_BITS'(1) << TIME_BITS;
   localparam logic signed [TQ_BITS-1:0] T_INF = TQ_BITS'(1) << (NUM_BITS + 1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] mover_left;
      logic signed [COORD_BITS-1:0] mover_top;
      logic signed [COORD_BITS-1:0] mover_right;
      logic signed [COORD_BITS-1:0] mover_bottom;
      logic signed [COORD_BITS-1:0] target_left;
      logic signed [COORD_BITS-1:0] target_top;
      logic signed [COORD_BITS-1:0] target_right;
      logic signed [COORD_BITS-1:0] target_bottom;
      logic signed [MOVE_BITS-1:0]  move_x;
      logic signed [MOVE_BITS-1:0]  move_y;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [TIME_BITS:0]   entry_time;
      logic [1:0]           struck_side;
   } rsp_type;

   // classified item handed from the front to the divider pipeline
   typedef struct packed {
      logic                                 reject;
      logic                                 x_zero;
      logic                                 y_zero;
      logic                                 x_neg;
      logic                                 y_neg;
      logic                                 dxe_pos;
      logic                                 dye_pos;
      logic [LANES-1:0]                     d_neg;
      logic [LANES-1:0][COORD_BITS-1:0]     d_mag;
      logic [MOVE_BITS-1:0]                 x_mag;
      logic [MOVE_BITS-1:0]                 y_mag;
   } cls_type;

endpackage
`default_nettype wire

[rtl/sbct_front.sv]
// front: overlap and broad-phase tests, entry and exit distances, divisor magnitudes
`default_nettype none
module sbct_front (
   input  sbct_pkg::req_type req,
   output sbct_pkg::cls_type cls
);
   import sbct_pkg::*;

   function automatic logic boxes_meet(
      input logic signed [SW_BITS-1:0] al, at, ar, ab,
      input logic signed [SW_BITS-1:0] bl, bt, br, bb);
      boxes_meet = !(al > br || ar < bl || at > bb || ab < bt);
   endfunction

   logic signed [SW_BITS-1:0]   al, at, ar, ab, bl, bt, br, bb;
   logic signed [SW_BITS-1:0]   sl, st, sr, sb;
   logic signed [MOVE_BITS-1:0] bias_x, bias_y, sum_x, sum_y;
   logic signed [WU_BITS-1:0]   wu_x, wu_y;
   logic                        x_pos, y_pos;
   logic signed [DIST_BITS-1:0] gap [LANES];

   assign al = SW_BITS'(req.mover_left);
   assign at = SW_BITS'(req.mover_top);
   assign ar = SW_BITS'(req.mover_right);
   assign ab = SW_BITS'(req.mover_bottom);
   assign bl = SW_BITS'(req.target_left);
   assign bt = SW_BITS'(req.target_top);
   assign br = SW_BITS'(req.target_right);
   assign bb = SW_BITS'(req.target_bottom);

   assign x_pos = !req.move_x[MOVE_BITS-1] && (|req.move_x);
   assign y_pos = !req.move_y[MOVE_BITS-1] && (|req.move_y);

   // truncate toward zero: bias negative values before the arithmetic shift
   assign bias_x = req.move_x[MOVE_BITS-1] ? MOVE_BITS'((1 << FRAC_BITS) - 1) : '0;
   assign bias_y = req.move_y[MOVE_BITS-1] ? MOVE_BITS'((1 << FRAC_BITS) - 1) : '0;
   assign sum_x  = req.move_x + bias_x;
   assign sum_y  = req.move_y + bias_y;
   assign wu_x   = sum_x[MOVE_BITS-1:FRAC_BITS];
   assign wu_y   = sum_y[MOVE_BITS-1:FRAC_BITS];

   assign sl = x_pos ? al : al + SW_BITS'(wu_x);
   assign sr = x_pos ? ar + SW_BITS'(wu_x) : ar;
   assign st = y_pos ? at : at + SW_BITS'(wu_y);
   assign sb = y_pos ? ab + SW_BITS'(wu_y) : ab;

   assign gap[LANE_XE] = x_pos ? DIST_BITS'(req.target_left) - DIST_BITS'(req.mover_right)
                               : DIST_BITS'(req.target_right) - DIST_BITS'(req.mover_left);
   assign gap[LANE_XX] = x_pos ? DIST_BITS'(req.target_right) - DIST_BITS'(req.mover_left)
                               : DIST_BITS'(req.target_left) - DIST_BITS'(req.mover_right);
   assign gap[LANE_YE] = y_pos ? DIST_BITS'(req.target_top) - DIST_BITS'(req.mover_bottom)
                               : DIST_BITS'(req.target_bottom) - DIST_BITS'(req.mover_top);
   assign gap[LANE_YX] = y_pos ? DIST_BITS'(req.target_bottom) - DIST_BITS'(req.mover_top)
                               : DIST_BITS'(req.target_top) - DIST_BITS'(req.mover_bottom);

   always_comb begin
      cls.reject  = boxes_meet(al, at, ar, ab, bl, bt, br, bb)
                    || !boxes_meet(sl, st, sr, sb, bl, bt, br, bb);
      cls.x_zero  = !(|req.move_x);
      cls.y_zero  = !(|req.move_y);
      cls.x_neg   = req.move_x[MOVE_BITS-1];
      cls.y_neg   = req.move_y[MOVE_BITS-1];
      cls.x_mag   = req.move_x[MOVE_BITS-1] ? MOVE_BITS'(-req.move_x) : req.move_x;
      cls.y_mag   = req.move_y[MOVE_BITS-1] ? MOVE_BITS'(-req.move_y) : req.move_y;
      cls.dxe_pos = !gap[LANE_XE][DIST_BITS-1] && (|gap[LANE_XE]);
      cls.dye_pos = !gap[LANE_YE][DIST_BITS-1] && (|gap[LANE_YE]);
      for (int l = 0; l < LANES; l++) begin
         cls.d_neg[l] = gap[l][DIST_BITS-1];
         cls.d_mag[l] = gap[l][DIST_BITS-1] ? COORD_BITS'(-gap[l])
                                            : COORD_BITS'(gap[l]);
      end
   end

endmodule
`default_nettype wire

[rtl/sbct_mid_queue.sv]
// short queue of classified items between the front and the divider pipeline
`default_nettype none
module sbct_mid_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbct_pkg::cls_type push_data,
   output logic              full,
   input  logic              pop,
   output sbct_pkg::cls_type pop_data,
   output logic              empty
);
   import sbct_pkg::*;

   cls_type            mem_ff [MID_DEPTH];
   logic [MID_AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [MID_AW:0]    cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = cnt_ff == (MID_AW + 1)'(MID_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (MID_AW + 1)'(do_push) - (MID_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/sbct_back.sv]
// back: four pipelined radix-4 dividers for the axis times, then the hit decision
`default_nettype none
module sbct_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sbct_pkg::cls_type in_cls,
   output logic              out_valid,
   output sbct_pkg::rsp_type out_rsp
);
   import sbct_pkg::*;

   typedef struct packed {
      logic                 reject;
      logic                 x_zero;
      logic                 y_zero;
      logic                 x_neg;
      logic                 y_neg;
      logic                 dxe_pos;
      logic                 dye_pos;
      logic [LANES-1:0]     d_neg;
      logic [MOVE_BITS-1:0] x_mag;
      logic [MOVE_BITS-1:0] y_mag;
   } ctl_type;

   // one restoring step: shift in the next dividend bit, subtract when it fits
   function automatic logic [MOVE_BITS+NUM_BITS-1:0] div_step(
      input logic [MOVE_BITS-1:0] rem,
      input logic [NUM_BITS-1:0]  work,
      input logic [MOVE_BITS-1:0] dvs);
      logic [MOVE_BITS:0] r2;
      logic [MOVE_BITS:0] diff;
      r2   = {rem, work[NUM_BITS-1]};
      diff = r2 - {1'b0, dvs};
      if (r2 >= {1'b0, dvs}) begin
         div_step = {diff[MOVE_BITS-1:0], work[NUM_BITS-2:0], 1'b1};
      end else begin
         div_step = {r2[MOVE_BITS-1:0], work[NUM_BITS-2:0], 1'b0};
      end
   endfunction

   logic [LANES-1:0][MOVE_BITS-1:0] rem_src  [DIV_STAGES];
   logic [LANES-1:0][NUM_BITS-1:0]  work_src [DIV_STAGES];
   logic [LANES-1:0][MOVE_BITS-1:0] rem_in   [DIV_STAGES];
   logic [LANES-1:0][NUM_BITS-1:0]  work_in  [DIV_STAGES];
   logic [LANES-1:0][MOVE_BITS-1:0] rem_ff   [DIV_STAGES];
   logic [LANES-1:0][NUM_BITS-1:0]  work_ff  [DIV_STAGES];
   ctl_type                         ctl_in   [DIV_STAGES];
   ctl_type                         ctl_ff   [DIV_STAGES];
   logic [DIV_STAGES-1:0]           vld_in, vld_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_load
         always_comb begin
            vld_in[s]         = in_valid;
            ctl_in[s].reject  = in_cls.reject;
            ctl_in[s].x_zero  = in_cls.x_zero;
            ctl_in[s].y_zero  = in_cls.y_zero;
            ctl_in[s].x_neg   = in_cls.x_neg;
            ctl_in[s].y_neg   = in_cls.y_neg;
            ctl_in[s].dxe_pos = in_cls.dxe_pos;
            ctl_in[s].dye_pos = in_cls.dye_pos;
            ctl_in[s].d_neg   = in_cls.d_neg;
            ctl_in[s].x_mag   = in_cls.x_mag;
            ctl_in[s].y_mag   = in_cls.y_mag;
            for (int l = 0; l < LANES; l++) begin
               rem_src[s][l]  = '0;
               work_src[s][l] = NUM_BITS'(in_cls.d_mag[l]) << (FRAC_BITS + TIME_BITS);
            end
         end
      end else begin : g_chain
         always_comb begin
            vld_in[s]   = vld_ff[s-1];
            ctl_in[s]   = ctl_ff[s-1];
            rem_src[s]  = rem_ff[s-1];
            work_src[s] = work_ff[s-1];
         end
      end

      always_comb begin : p_div
         logic [MOVE_BITS-1:0] dvs;
         logic [MOVE_BITS-1:0] r;
         logic [NUM_BITS-1:0]  w;
         for (int l = 0; l < LANES; l++) begin
            dvs = (l == LANE_XE || l == LANE_XX) ? ctl_in[s].x_mag : ctl_in[s].y_mag;
            r   = rem_src[s][l];
            w   = work_src[s][l];
            for (int k = 0; k < RADIX_BITS; k++) begin
               {r, w} = div_step(r, w, dvs);
            end
            rem_in[s][l]  = r;
            work_in[s][l] = w;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
         rem_ff[s]  <= rem_in[s];
         work_ff[s] <= work_in[s];
         ctl_ff[s]  <= ctl_in[s];
      end
   end

   // sign fix and unbounded axes
   logic signed [TQ_BITS-1:0] tq_in [LANES];
   logic signed [TQ_BITS-1:0] tq_ff [LANES];
   ctl_type                   fix_ctl_ff;
   logic                      fix_vld_ff;

   always_comb begin : p_fix
      logic                      zero;
      logic                      neg;
      logic signed [TQ_BITS-1:0] q;
      for (int l = 0; l < LANES; l++) begin
         if (l == LANE_XE || l == LANE_XX) begin
            zero = ctl_ff[DIV_STAGES-1].x_zero;
            neg  = ctl_ff[DIV_STAGES-1].d_neg[l] ^ ctl_ff[DIV_STAGES-1].x_neg;
         end else begin
            zero = ctl_ff[DIV_STAGES-1].y_zero;
            neg  = ctl_ff[DIV_STAGES-1].d_neg[l] ^ ctl_ff[DIV_STAGES-1].y_neg;
         end
         q = signed'(TQ_BITS'(work_ff[DIV_STAGES-1][l]));
         if (zero) begin
            tq_in[l] = (l == LANE_XE || l == LANE_YE) ? -T_INF : T_INF;
         end else begin
            tq_in[l] = neg ? -q : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_vld_ff <= 1'b0;
      end else begin
         fix_vld_ff <= vld_ff[DIV_STAGES-1];
      end
      fix_ctl_ff <= ctl_ff[DIV_STAGES-1];
      tq_ff      <= tq_in;
   end

   // decision
   rsp_type rsp_in, rsp_ff;
   logic    out_vld_ff;

   always_comb begin : p_decide
      logic signed [TQ_BITS-1:0] ent;
      logic signed [TQ_BITS-1:0] ext;
      logic                      miss;
      ent  = (tq_ff[LANE_XE] > tq_ff[LANE_YE]) ? tq_ff[LANE_XE] : tq_ff[LANE_YE];
      ext  = (tq_ff[LANE_XX] < tq_ff[LANE_YX]) ? tq_ff[LANE_XX] : tq_ff[LANE_YX];
      miss = fix_ctl_ff.reject || (ent > ext)
             || (tq_ff[LANE_XE][TQ_BITS-1] && tq_ff[LANE_YE][TQ_BITS-1])
             || (tq_ff[LANE_XE] > T_ONE) || (tq_ff[LANE_YE] > T_ONE);
      rsp_in.hit = !miss;
      if (miss) begin
         rsp_in.entry_time  = T_ONE[TIME_BITS:0];
         rsp_in.struck_side = SIDE_RIGHT;
      end else begin
         rsp_in.entry_time = ent[TIME_BITS:0];
         if (tq_ff[LANE_XE] > tq_ff[LANE_YE]) begin
            rsp_in.struck_side = fix_ctl_ff.dxe_pos ? SIDE_RIGHT : SIDE_LEFT;
         end else begin
            rsp_in.struck_side = fix_ctl_ff.dye_pos ? SIDE_BOTTOM : SIDE_TOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= fix_vld_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = out_vld_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

[rtl/sbct_out_queue.sv]
// result queue that holds every result the divider pipeline has in flight
`default_nettype none
module sbct_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbct_pkg::rsp_type push_data,
   output logic              full,
   input  logic              pop,
   output sbct_pkg::rsp_type pop_data,
   output logic              empty
);
   import sbct_pkg::*;

   rsp_type            mem_ff [OUT_DEPTH];
   logic [OUT_AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [OUT_AW:0]    cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = cnt_ff == (OUT_AW + 1)'(OUT_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (OUT_AW + 1)'(do_push) - (OUT_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/swept_box_collision_time_unit.sv]
// swept box collision time unit: top level
// Use: write one box pair per beat into the request queue (req_push while
// req_full is low); read one result per beat from the response queue
// (rsp_pop while rsp_empty is low). Every request gives exactly one result,
// in request order: hit flag, entry time in Q1.16 and struck side.
// Path from an accepted request to rsp_empty going low: classification into
// a 4-entry queue, 20 radix-4 divider stages for the four axis times, sign
// fix, decision and the result queue write.
// Throughput: one beat per cycle while no queue is full; the four pipelined
// dividers take a new pair every cycle while a result queue credit is free.
// A credit counter issues work only while the 32-entry result queue has a
// free slot for it, so a stalled receiver first fills that queue, then the
// request queue, then holds req_full high; nothing is dropped.
// Reset clears all queues and pipeline valids; no clearing pass is needed.
`default_nettype none
module swept_box_collision_time_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  sbct_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output sbct_pkg::rsp_type rsp_data
);
   import sbct_pkg::*;

   cls_type                cls_front, cls_mid;
   logic                   mid_empty, issue;
   logic                   back_valid;
   rsp_type                back_rsp;
   logic                   out_full;
   logic [CREDIT_BITS-1:0] credit_ff, credit_in;
   logic                   rsp_taken;
   logic                   rsp_time_ok, rsp_miss_ok;

   sbct_front u_front (
      .req (req_data),
      .cls (cls_front)
   );

   sbct_mid_queue u_mid (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cls_front),
      .full      (req_full),
      .pop       (issue),
      .pop_data  (cls_mid),
      .empty     (mid_empty)
   );

   assign issue     = !mid_empty && (credit_ff != '0);
   assign rsp_taken = rsp_pop && !rsp_empty;

   always_comb begin
      credit_in = credit_ff - CREDIT_BITS'(issue) + CREDIT_BITS'(rsp_taken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= CREDIT_BITS'(OUT_DEPTH);
      end else begin
         credit_ff <= credit_in;
      end
   end

   sbct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue),
      .in_cls    (cls_mid),
      .out_valid (back_valid),
      .out_rsp   (back_rsp)
   );

   sbct_out_queue u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_time_ok = rsp_data.entry_time <= T_ONE[TIME_BITS:0];
   assign rsp_miss_ok = rsp_data.entry_time == T_ONE[TIME_BITS:0]
                        && rsp_data.struck_side == SIDE_RIGHT;

`include "swept_box_collision_time_unit_assert.svh"

   // credits must keep the result queue from ever overflowing
   `SBCT_ASSERT_NEVER(a_no_out_overflow, clock, reset, back_valid && out_full)
   `SBCT_ASSERT_NEVER(a_credit_bound, clock, reset, credit_ff > CREDIT_BITS'(OUT_DEPTH))
   `SBCT_ASSERT_IMPLY(a_hit_time, clock, reset, !rsp_empty && rsp_data.hit, rsp_time_ok)
   `SBCT_ASSERT_IMPLY(a_miss_fields, clock, reset, !rsp_empty && !rsp_data.hit, rsp_miss_ok)

endmodule
`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench of the swept box collision time unit
`timescale 1ns / 1ps

module tb_top;
   import sbct_pkg::*;

   localparam longint UNBOUNDED = longint'(1) << 62;
   localparam longint FRAME_ONE = longint'(1) << TIME_BITS;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   int      sent_count = 0;
   bit      quiet_window = 1'b0;

   swept_box_collision_time_unit DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   class collision_scoreboard;
      rsp_type pending[$];
      int      errors = 0;
      int      hits = 0;
      int      checked = 0;

      static function bit boxes_touch(longint al, longint at, longint ar, longint ab,
                                      longint bl, longint bt, longint br, longint bb);
         return !(al > br || ar < bl || at > bb || ab < bt);
      endfunction

      static function rsp_type collision_outcome(req_type r);
         longint  al, at, ar, ab, bl, bt, br, bb, mx, my;
         longint  sl, st, sr, sb;
         longint  dxe, dxx, dye, dyx, txe, txx, tye, tyx, ent, ext;
         rsp_type o;
         al = r.mover_left;  at = r.mover_top;  ar = r.mover_right;  ab = r.mover_bottom;
         bl = r.target_left; bt = r.target_top; br = r.target_right; bb = r.target_bottom;
         mx = r.move_x;      my = r.move_y;
         o.hit = 1'b0;
         o.entry_time = FRAME_ONE[TIME_BITS:0];
         o.struck_side = SIDE_RIGHT;
         if (boxes_touch(al, at, ar, ab, bl, bt, br, bb)) return o;
         sl = al; st = at; sr = ar; sb = ab;
         // displacement truncated toward zero to whole units
         if (mx > 0) sr += mx / (longint'(1) << FRAC_BITS);
         else sl += mx / (longint'(1) << FRAC_BITS);
         if (my > 0) sb += my / (longint'(1) << FRAC_BITS);
         else st += my / (longint'(1) << FRAC_BITS);
         if (!boxes_touch(sl, st, sr, sb, bl, bt, br, bb)) return o;
         if (mx > 0) begin
            dxe = bl - ar; dxx = br - al;
         end else begin
            dxe = br - al; dxx = bl - ar;
         end
         if (my > 0) begin
            dye = bt - ab; dyx = bb - at;
         end else begin
            dye = bb - at; dyx = bt - ab;
         end
         if (mx == 0) begin
            txe = -UNBOUNDED; txx = UNBOUNDED;
         end else begin
            txe = (dxe * (longint'(1) << (FRAC_BITS + TIME_BITS))) / mx;
            txx = (dxx * (longint'(1) << (FRAC_BITS + TIME_BITS))) / mx;
         end
         if (my == 0) begin
            tye = -UNBOUNDED; tyx = UNBOUNDED;
         end else begin
            tye = (dye * (longint'(1) << (FRAC_BITS + TIME_BITS))) / my;
            tyx = (dyx * (longint'(1) << (FRAC_BITS + TIME_BITS))) / my;
         end
         ent = (txe > tye) ? txe : tye;
         ext = (txx < tyx) ? txx : tyx;
         if (ent > ext || (txe < 0 && tye < 0) || txe > FRAME_ONE || tye > FRAME_ONE)
            return o;
         if (txe > tye) o.struck_side = (dxe > 0) ? SIDE_RIGHT : SIDE_LEFT;
         else o.struck_side = (dye > 0) ? SIDE_BOTTOM : SIDE_TOP;
         o.hit = 1'b1;
         o.entry_time = ent[TIME_BITS:0];
         return o;
      endfunction

      function void note_pair(req_type r);
         rsp_type e;
         e = collision_outcome(r);
         if (e.hit) hits++;
         pending.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch at result %0d: %s got %0d expected %0d", checked, what, got, want);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("unexpected beat, hit", got.hit, 0);
            return;
         end
         want = pending.pop_front();
         if (got.hit !== want.hit) report("hit", got.hit, want.hit);
         if (got.entry_time !== want.entry_time)
            report("entry_time", got.entry_time, want.entry_time);
         if (got.struck_side !== want.struck_side)
            report("struck_side", got.struck_side, want.struck_side);
         checked++;
      endtask
   endclass

   collision_scoreboard sb = new();

   function automatic bit idle_roll();
      return !quiet_window && ($urandom_range(99) < 13);
   endfunction

   task automatic push_pair(req_type r);
      while (idle_roll()) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      sb.note_pair(r);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic push_boxes(int ml, int mt, int mr, int mb, int tl, int tt, int tr, int tb,
                             int mx, int my);
      req_type r;
      r.mover_left    = COORD_BITS'(ml);
      r.mover_top     = COORD_BITS'(mt);
      r.mover_right   = COORD_BITS'(mr);
      r.mover_bottom  = COORD_BITS'(mb);
      r.target_left   = COORD_BITS'(tl);
      r.target_top    = COORD_BITS'(tt);
      r.target_right  = COORD_BITS'(tr);
      r.target_bottom = COORD_BITS'(tb);
      r.move_x        = MOVE_BITS'(mx);
      r.move_y        = MOVE_BITS'(my);
      push_pair(r);
   endtask

   // aimed pair: target near the mover, displacement mostly toward it
   task automatic push_aimed_pair();
      int ml, mt, w, h, tl, tt, mx, my;
      ml = $urandom_range(4000) - 2000;
      mt = $urandom_range(4000) - 2000;
      w = $urandom_range(40);
      h = $urandom_range(40);
      tl = ml + $urandom_range(600) - 300;
      tt = mt + $urandom_range(600) - 300;
      mx = (tl - ml) * 256 + $urandom_range(40000) - 20000;
      my = (tt - mt) * 256 + $urandom_range(40000) - 20000;
      if ($urandom_range(9) == 0) mx = 0;
      if ($urandom_range(9) == 0) my = 0;
      push_boxes(ml, mt, ml + w, mt + h, tl, tt, tl + $urandom_range(60),
                 tt + $urandom_range(60), mx, my);
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_pop <= !idle_roll();
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_data);
   end

   initial begin
      #20_000_000;
      $display("swept_box_collision_time_unit verification failed");
      $finish;
   end

   initial begin
      req_type      r;
      logic [191:0] raw;
      int           wait_cycles;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: overlap, shared edge, broad miss, each side struck, zero moves
      push_boxes(0, 0, 10, 10, 5, 5, 20, 20, 256, 256);
      push_boxes(0, 0, 10, 10, 10, 0, 20, 10, 2560, 0);
      push_boxes(0, 0, 10, 10, 100, 0, 110, 10, 2560, 0);
      push_boxes(0, 0, 10, 10, 20, 0, 30, 10, 5120, 0);
      push_boxes(20, 0, 30, 10, 0, 0, 10, 10, -5120, 0);
      push_boxes(0, 0, 10, 10, 0, 20, 10, 30, 0, 5120);
      push_boxes(0, 20, 10, 30, 0, 0, 10, 10, 0, -5120);
      push_boxes(0, 0, 10, 10, 20, 20, 30, 30, 5120, 5120);
      push_boxes(0, 0, 10, 10, 20, 20, 30, 30, 0, 0);
      push_boxes(0, 0, 10, 10, 11, 0, 20, 10, 256, 0);
      push_boxes(0, 0, 10, 10, 20, 0, 30, 10, 2560, 0);
      push_boxes(0, 0, 10, 10, 20, 5, 30, 8, 5200, 77);
      push_boxes(10, 10, 0, 0, 20, 0, 30, 10, 5120, 0);
      push_boxes(0, 0, 10, 10, 30, 0, 20, 10, 5120, 0);
      push_boxes(-32768, -32768, -32760, -32760, 32700, 32700, 32767, 32767,
                 8388607, 8388607);
      push_boxes(32760, 32760, 32767, 32767, -32768, -32768, -32700, -32700,
                 -8388608, -8388608);
      push_boxes(-32768, 0, -32768, 0, 32767, 0, 32767, 0, 8388607, 0);
      push_boxes(0, 0, 10, 10, 20, 0, 30, 10, 255, 0);
      push_boxes(0, 0, 10, 10, 20, 0, 30, 10, -5120, 0);
      push_boxes(0, 0, 10, 10, 15, 40, 25, 50, 5120, 1280);

      for (int i = 0; i < 450; i++) begin
         quiet_window = (i >= 150 && i < 250);
         if ($urandom_range(99) < 75) push_aimed_pair();
         else begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            r = raw[$bits(req_type)-1:0];
            push_pair(r);
         end
      end
      quiet_window = 1'b0;
      req_push <= 1'b0;

      wait_cycles = 0;
      while (sb.pending.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (sb.pending.size() != 0) sb.errors++;
      $display("%0d box pairs sent, %0d results checked, %0d of them hits",
               sent_count, sb.checked, sb.hits);
      if (sb.errors == 0) begin
         $display("swept_box_collision_time_unit verification clean");
      end else begin
         $display("swept_box_collision_time_unit verification failed");
      end
      $finish;
   end

endmodule

[swept_box_collision_time_unit.f]
+incdir+rtl
rtl/sbct_pkg.sv
rtl/sbct_front.sv
rtl/sbct_mid_queue.sv
rtl/sbct_back.sv
rtl/sbct_out_queue.sv
rtl/swept_box_collision_time_unit.sv
sim/tb_top.sv
